// File: hw/rtl/lfcr_pkg.sv
// Shared types and codes for the length-framed command receiver.
package lfcr_pkg;

    // Input item actions
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_TIMEOUT  = 3'd3;
    localparam logic [2:0] ST_BAD_CMD  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_MASTER_MODE = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT     = 3'd1;
    localparam logic [2:0] CFG_WRITE_CODE  = 3'd2;
    localparam logic [2:0] CFG_READ_CODE   = 3'd3;
    localparam logic [2:0] CFG_SETUP_CODE  = 3'd4;

    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [6:0]  WRITE_RESET   = 7'd1;
    localparam logic [6:0]  READ_RESET    = 7'd2;
    localparam logic [6:0]  SETUP_RESET   = 7'd3;
    localparam logic [7:0]  CMD_MASK      = 8'h7F;
    localparam logic [15:0] GAP_MAX       = 16'hFFFF;

    // Control from the parser to the frame bank store, one set per item
    typedef struct packed {
        logic step;
        logic wr_en;
        logic wr_bank;
        logic clr_en;
        logic clr_bank;
        logic rd_en;
        logic rd_bank;
    } lfcr_bank_ctl_t;

endpackage

// File: hw/rtl/length_framed_command_receiver.sv
// Top level of the length-framed command receiver.
// Takes one item per clock and gives its result in the cycle after acceptance;
// in_ready drops only while a result is held and out_ready is low. Each item
// does one header compare and at most one access to the single-port-per-side
// frame store of 2 x 2**PW bytes, which sets the one-item-per-cycle rate.
// Clearing a bank at frame end only zeroes its fill mark; a fill mark per bank
// stands in for the cleared contents, so there is no clearing pass after reset.
// Configuration writes are always taken and must only be made while idle.
module length_framed_command_receiver #(
    parameter int BANK_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  echo_byte,
    output logic [7:0]  byte_position,
    output logic        request_pending,
    output logic        reply_pending,
    output logic [7:0]  read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PW = $clog2(BANK_BYTES);

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_FUNC,
        PH_CMD,
        PH_PAYLOAD
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [7:0]     count_reg, count_next, count_plus;
    logic [PW-1:0]  pos_reg, pos_next, pos_plus;
    logic [7:0]     exp_len_reg, exp_len_next;
    logic [15:0]    gap_reg, gap_next;
    logic           wbank_reg, wbank_next;
    logic           dbank_reg, dbank_next;
    logic           req_reg, req_next;
    logic           rep_reg, rep_next;

    logic           master_reg;
    logic [15:0]    timeout_reg;
    logic [6:0]     write_code_reg, read_code_reg, setup_code_reg;

    logic           out_valid_reg;
    logic [2:0]     status_reg, status_next;
    logic [7:0]     echo_reg, echo_next;
    logic [7:0]     bpos_reg, bpos_next;

    logic           accept;
    logic           late;
    logic           code_ok;
    logic [6:0]     cmd;
    logic [11:0]    rem;
    logic [PW-1:0]  rd_pos;
    lfcr_pkg::lfcr_bank_ctl_t ctl;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign cmd      = 7'(rx_byte & lfcr_pkg::CMD_MASK);
    assign late     = gap_reg > timeout_reg;
    assign code_ok  = (cmd == write_code_reg) || (cmd == read_code_reg)
                   || (cmd == setup_code_reg);
    assign count_plus = count_reg + 8'd1;
    // The store position follows the byte count modulo the bank size, so it
    // also returns to zero when the 8-bit count wraps.
    assign pos_plus   = (pos_reg == PW'(BANK_BYTES - 1) || count_reg == 8'hFF)
                      ? '0 : pos_reg + 1'b1;

    // read_index reduced modulo the bank size by conditional subtraction
    always_comb
    begin
        rem = 12'(read_index);
        for (int k = 3; k >= 0; k--)
        begin
            if (rem >= 12'(BANK_BYTES * (2 ** k)))
            begin
                rem = rem - 12'(BANK_BYTES * (2 ** k));
            end
        end
        rd_pos = rem[PW-1:0];
    end

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        exp_len_next = exp_len_reg;
        gap_next     = gap_reg;
        wbank_next   = wbank_reg;
        dbank_next   = dbank_reg;
        req_next     = req_reg;
        rep_next     = rep_reg;
        status_next  = lfcr_pkg::ST_NONE;
        echo_next    = 8'd0;
        bpos_next    = 8'd0;
        ctl          = '0;
        ctl.step     = accept;
        ctl.wr_bank  = wbank_reg;
        ctl.clr_bank = !wbank_reg;
        ctl.rd_bank  = dbank_reg;

        unique case (action)
            lfcr_pkg::ACT_BYTE:
            begin
                unique case (phase_reg)
                    PH_LENGTH:
                    begin
                        ctl.wr_en    = 1'b1;
                        count_next   = count_plus;
                        pos_next     = pos_plus;
                        exp_len_next = rx_byte;
                        phase_next   = PH_FUNC;
                        gap_next     = '0;
                        status_next  = lfcr_pkg::ST_ACCEPTED;
                        echo_next    = rx_byte;
                        bpos_next    = 8'(pos_reg);
                    end
                    PH_FUNC:
                    begin
                        if (late)
                        begin
                            status_next = lfcr_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            ctl.wr_en   = 1'b1;
                            count_next  = count_plus;
                            pos_next    = pos_plus;
                            phase_next  = PH_CMD;
                            gap_next    = '0;
                            status_next = lfcr_pkg::ST_ACCEPTED;
                            echo_next   = rx_byte;
                            bpos_next   = 8'(pos_reg);
                        end
                    end
                    PH_CMD:
                    begin
                        // The command byte is stored unmasked even when dropped.
                        ctl.wr_en  = 1'b1;
                        count_next = count_plus;
                        pos_next   = pos_plus;
                        priority if (!code_ok)
                        begin
                            status_next = lfcr_pkg::ST_BAD_CMD;
                        end
                        else if (late)
                        begin
                            status_next = lfcr_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            phase_next  = PH_PAYLOAD;
                            gap_next    = '0;
                            status_next = lfcr_pkg::ST_ACCEPTED;
                            echo_next   = 8'(cmd);
                            bpos_next   = 8'(pos_reg);
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        ctl.wr_en   = 1'b1;
                        count_next  = count_plus;
                        pos_next    = pos_plus;
                        status_next = lfcr_pkg::ST_ACCEPTED;
                        echo_next   = rx_byte;
                        bpos_next   = 8'(pos_reg);
                        if (count_plus == exp_len_reg)
                        begin
                            phase_next  = PH_LENGTH;
                            if (master_reg)
                            begin
                                rep_next = 1'b1;
                            end
                            else
                            begin
                                req_next = 1'b1;
                            end
                            dbank_next  = wbank_reg;
                            wbank_next  = !wbank_reg;
                            ctl.clr_en  = 1'b1;
                            count_next  = '0;
                            pos_next    = '0;
                            status_next = lfcr_pkg::ST_COMPLETE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            lfcr_pkg::ACT_TICK:
            begin
                if (gap_reg != lfcr_pkg::GAP_MAX)
                begin
                    gap_next = gap_reg + 16'd1;
                end
            end
            lfcr_pkg::ACT_RELEASE:
            begin
            end
            lfcr_pkg::ACT_READ:
            begin
                ctl.rd_en = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Timeouts, bad commands and release all abandon the frame.
        if (status_next == lfcr_pkg::ST_TIMEOUT || status_next == lfcr_pkg::ST_BAD_CMD
            || action == lfcr_pkg::ACT_RELEASE)
        begin
            req_next     = 1'b0;
            rep_next     = 1'b0;
            count_next   = '0;
            pos_next     = '0;
            exp_len_next = '0;
            wbank_next   = 1'b0;
            phase_next   = PH_LENGTH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LENGTH;
            count_reg      <= '0;
            pos_reg        <= '0;
            exp_len_reg    <= '0;
            gap_reg        <= '0;
            wbank_reg      <= 1'b0;
            dbank_reg      <= 1'b0;
            req_reg        <= 1'b0;
            rep_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            master_reg     <= 1'b0;
            timeout_reg    <= lfcr_pkg::TIMEOUT_RESET;
            write_code_reg <= lfcr_pkg::WRITE_RESET;
            read_code_reg  <= lfcr_pkg::READ_RESET;
            setup_code_reg <= lfcr_pkg::SETUP_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                pos_reg     <= pos_next;
                exp_len_reg <= exp_len_next;
                gap_reg     <= gap_next;
                wbank_reg   <= wbank_next;
                dbank_reg   <= dbank_next;
                req_reg     <= req_next;
                rep_reg     <= rep_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    lfcr_pkg::CFG_MASTER_MODE: master_reg     <= cfg_data[0];
                    lfcr_pkg::CFG_TIMEOUT:     timeout_reg    <= cfg_data;
                    lfcr_pkg::CFG_WRITE_CODE:  write_code_reg <= cfg_data[6:0];
                    lfcr_pkg::CFG_READ_CODE:   read_code_reg  <= cfg_data[6:0];
                    lfcr_pkg::CFG_SETUP_CODE:  setup_code_reg <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            echo_reg   <= echo_next;
            bpos_reg   <= bpos_next;
        end
    end

    lfcr_frame_bank #(
        .BANK_BYTES (BANK_BYTES)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_pos  (pos_reg),
        .wr_data (rx_byte),
        .rd_pos  (rd_pos),
        .rd_data (read_data)
    );

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign echo_byte       = echo_reg;
    assign byte_position   = bpos_reg;
    assign request_pending = req_reg;
    assign reply_pending   = rep_reg;

endmodule

// File: hw/rtl/lfcr_frame_bank.sv
// Two-bank frame store with per-bank fill marks and a registered read port.
module lfcr_frame_bank #(
    parameter int BANK_BYTES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfcr_pkg::lfcr_bank_ctl_t      ctl,
    input  logic [$clog2(BANK_BYTES)-1:0] wr_pos,
    input  logic [7:0]                    wr_data,
    input  logic [$clog2(BANK_BYTES)-1:0] rd_pos,
    output logic [7:0]                    rd_data
);

    localparam int PW = $clog2(BANK_BYTES);

    logic [7:0]  mem [0:(2*(2**PW))-1];
    logic [PW:0] fill_reg [0:1];
    logic [PW:0] fill_next [0:1];
    logic [7:0]  q_reg;
    logic        hit_reg;
    logic        rd_hit;

    // Bytes are always written from position zero upwards after a clear, so
    // every entry at or above the fill mark still holds its cleared value.
    assign rd_hit = ctl.rd_en && ({1'b0, rd_pos} < fill_reg[ctl.rd_bank]);

    always_comb
    begin
        fill_next[0] = fill_reg[0];
        fill_next[1] = fill_reg[1];
        if (ctl.step && ctl.wr_en && ({1'b0, wr_pos} == fill_reg[ctl.wr_bank]))
        begin
            fill_next[ctl.wr_bank] = fill_reg[ctl.wr_bank] + 1'b1;
        end
        if (ctl.step && ctl.clr_en)
        begin
            fill_next[ctl.clr_bank] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            fill_reg[0] <= fill_next[0];
            fill_reg[1] <= fill_next[1];
            if (ctl.step)
            begin
                hit_reg <= rd_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && ctl.wr_en)
        begin
            mem[{ctl.wr_bank, wr_pos}] <= wr_data;
        end
        if (ctl.step && rd_hit)
        begin
            q_reg <= mem[{ctl.rd_bank, rd_pos}];
        end
    end

    assign rd_data = hit_reg ? q_reg : 8'd0;

endmodule

// File: hw/rtl/lfcr_checker.sv
// Port-level checks for the length-framed command receiver, bound to the top level.
module lfcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [7:0] echo_byte,
    input logic [7:0] byte_position,
    input logic       request_pending,
    input logic       reply_pending
);

    // A held result's status and echo byte must not change under backpressure.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(echo_byte))
        else $error("result changed while stalled");

    // Input side only stalls while a result waits to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with no pending result");

    // A completed frame always leaves one of the ready flags raised.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == lfcr_pkg::ST_COMPLETE |-> request_pending || reply_pending)
        else $error("frame complete without a ready flag");

    // Timeout and bad-command drops clear both flags and report no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lfcr_pkg::ST_TIMEOUT || status == lfcr_pkg::ST_BAD_CMD)
        |-> !request_pending && !reply_pending && echo_byte == 8'd0
            && byte_position == 8'd0)
        else $error("drop left flags or byte fields set");

endmodule

bind length_framed_command_receiver lfcr_checker u_lfcr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .echo_byte       (echo_byte),
    .byte_position   (byte_position),
    .request_pending (request_pending),
    .reply_pending   (reply_pending)
);

// File: bench/length_framed_command_receiver_tb.sv
// Self-checking testbench for the length-framed command receiver.
module length_framed_command_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANK_BYTES  = 256;
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {
        HDR_LENGTH,
        HDR_FUNCTION,
        HDR_COMMAND,
        HDR_PAYLOAD
    } hdr_phase_t;

    typedef struct packed {
        logic [2:0] st;
        logic [7:0] echo;
        logic [7:0] pos;
        logic       req;
        logic       rep;
        logic [7:0] rdata;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic [7:0]  read_index;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [7:0]  echo_byte;
    logic [7:0]  byte_position;
    logic        request_pending;
    logic        reply_pending;
    logic [7:0]  read_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predicted state of the receiver and its registers
    hdr_phase_t  hdr_phase;
    logic [7:0]  rx_count;
    logic [7:0]  frame_len;
    logic [15:0] tick_gap;
    logic        fill_bank;
    logic        ready_bank;
    logic [7:0]  bank_mem [2][BANK_BYTES];
    logic        req_flag;
    logic        rep_flag;
    logic        cfg_master;
    logic [15:0] cfg_timeout;
    logic [6:0]  cfg_write_code;
    logic [6:0]  cfg_read_code;
    logic [6:0]  cfg_setup_code;

    frame_result_t expected_results [$];
    int unsigned   mismatches;
    int unsigned   items_sent;
    int unsigned   quiet_cycles;
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;

    length_framed_command_receiver #(
        .BANK_BYTES (BANK_BYTES)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .rx_byte         (rx_byte),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .echo_byte       (echo_byte),
        .byte_position   (byte_position),
        .request_pending (request_pending),
        .reply_pending   (reply_pending),
        .read_data       (read_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] store_rx_byte(input logic [7:0] b);
        logic [7:0] slot;
        slot = 8'(rx_count % BANK_BYTES);
        bank_mem[fill_bank][slot] = b;
        rx_count = rx_count + 8'd1;
        return slot;
    endfunction

    function automatic void abort_frame();
        req_flag  = 1'b0;
        rep_flag  = 1'b0;
        rx_count  = '0;
        frame_len = '0;
        fill_bank = 1'b0;
        hdr_phase = HDR_LENGTH;
    endfunction

    function automatic frame_result_t parse_item(input logic [1:0] act, input logic [7:0] b,
                                                 input logic [7:0] idx);
        frame_result_t r;
        logic [6:0]    code;
        logic [7:0]    slot;
        r = '0;
        case (act)
            lfcr_pkg::ACT_BYTE:
            begin
                case (hdr_phase)
                    HDR_LENGTH:
                    begin
                        r.pos     = store_rx_byte(b);
                        frame_len = b;
                        hdr_phase = HDR_FUNCTION;
                        tick_gap  = '0;
                        r.st      = lfcr_pkg::ST_ACCEPTED;
                        r.echo    = b;
                    end
                    HDR_FUNCTION:
                    begin
                        if (tick_gap > cfg_timeout)
                        begin
                            abort_frame();
                            r.st = lfcr_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            r.pos     = store_rx_byte(b);
                            hdr_phase = HDR_COMMAND;
                            tick_gap  = '0;
                            r.st      = lfcr_pkg::ST_ACCEPTED;
                            r.echo    = b;
                        end
                    end
                    HDR_COMMAND:
                    begin
                        // The command byte is stored unmasked even when the frame is dropped.
                        code = b[6:0];
                        slot = store_rx_byte(b);
                        if (code != cfg_write_code && code != cfg_read_code &&
                            code != cfg_setup_code)
                        begin
                            abort_frame();
                            r.st = lfcr_pkg::ST_BAD_CMD;
                        end
                        else if (tick_gap > cfg_timeout)
                        begin
                            abort_frame();
                            r.st = lfcr_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            hdr_phase = HDR_PAYLOAD;
                            tick_gap  = '0;
                            r.st      = lfcr_pkg::ST_ACCEPTED;
                            r.echo    = b & lfcr_pkg::CMD_MASK;
                            r.pos     = slot;
                        end
                    end
                    default:
                    begin
                        r.pos  = store_rx_byte(b);
                        r.echo = b;
                        r.st   = lfcr_pkg::ST_ACCEPTED;
                        if (rx_count == frame_len)
                        begin
                            hdr_phase = HDR_LENGTH;
                            if (cfg_master)
                                rep_flag = 1'b1;
                            else
                                req_flag = 1'b1;
                            ready_bank = fill_bank;
                            fill_bank  = ~fill_bank;
                            for (int i = 0; i < BANK_BYTES; i++)
                                bank_mem[fill_bank][i] = '0;
                            rx_count = '0;
                            r.st     = lfcr_pkg::ST_COMPLETE;
                        end
                    end
                endcase
            end
            lfcr_pkg::ACT_TICK:
            begin
                if (tick_gap != lfcr_pkg::GAP_MAX)
                    tick_gap = tick_gap + 16'd1;
            end
            lfcr_pkg::ACT_RELEASE:
                abort_frame();
            default:
                r.rdata = bank_mem[ready_bank][idx % BANK_BYTES];
        endcase
        r.req = req_flag;
        r.rep = rep_flag;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $realtime, name, want_v, got_v);
        end
    endtask

    // Mirrors config writes, predicts on every accepted item, checks every
    // accepted result and guards against a hang.
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lfcr_pkg::CFG_MASTER_MODE: cfg_master     = cfg_data[0];
                    lfcr_pkg::CFG_TIMEOUT:     cfg_timeout    = cfg_data;
                    lfcr_pkg::CFG_WRITE_CODE:  cfg_write_code = cfg_data[6:0];
                    lfcr_pkg::CFG_READ_CODE:   cfg_read_code  = cfg_data[6:0];
                    lfcr_pkg::CFG_SETUP_CODE:  cfg_setup_code = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_results.push_back(parse_item(action, rx_byte, read_index));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result expected none got status %0h echo %0h pos %0h",
                             $realtime, status, echo_byte, byte_position);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 8'(want.st), 8'(status));
                    check_field("echo_byte", want.echo, echo_byte);
                    check_field("byte_position", want.pos, byte_position);
                    check_field("request_pending", 8'(want.req), 8'(request_pending));
                    check_field("reply_pending", 8'(want.rep), 8'(reply_pending));
                    check_field("read_data", want.rdata, read_data);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    always @(negedge clk)
        out_ready = ($urandom_range(99) >= recv_stall_pct);

    // Called at a falling edge; returns at the falling edge after acceptance,
    // so the predicted state is already up to date. Valid stays high for the
    // next item unless the sender idles.
    task automatic send_item(input logic [1:0] act, input logic [7:0] b, input logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        action     = act;
        rx_byte    = b;
        read_index = idx;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(lfcr_pkg::ACT_BYTE, b, 8'($urandom));
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(lfcr_pkg::ACT_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [6:0] pick_code();
        case ($urandom_range(4))
            0:       return 7'd0;
            1:       return 7'h7F;
            default: return 7'($urandom);
        endcase
    endfunction

    // One frame with random content. With faults allowed, header gaps may run past
    // a timeout below eight, the command may be bad and the payload may be released.
    task automatic send_frame(input logic [7:0] len, input bit faults);
        int unsigned gap_hi;
        int unsigned pick;
        logic [6:0]  code;
        logic [7:0]  cmd;
        gap_hi = (cfg_timeout < 16'd8) ? int'(cfg_timeout) + 1 : 2;
        send_byte(len);
        if (faults && $urandom_range(2) == 0)
            send_ticks($urandom_range(0, gap_hi));
        send_byte(8'($urandom));
        if (faults && $urandom_range(2) == 0)
            send_ticks($urandom_range(0, gap_hi));
        pick = $urandom_range(2);
        code = (pick == 0) ? cfg_write_code : (pick == 1) ? cfg_read_code : cfg_setup_code;
        cmd  = {1'($urandom), code};
        if (faults && $urandom_range(9) == 0)
            cmd = 8'($urandom);
        send_byte(cmd);
        while (hdr_phase == HDR_PAYLOAD)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                send_item(lfcr_pkg::ACT_READ, 8'($urandom), 8'($urandom));
            else if (pick < 7)
                send_ticks(1);
            else if (faults && pick < 8)
                send_item(lfcr_pkg::ACT_RELEASE, 8'($urandom), 8'($urandom));
            else
                send_byte(8'($urandom));
        end
        if ($urandom_range(1) == 0)
            send_item(lfcr_pkg::ACT_READ, 8'($urandom), 8'($urandom_range(0, len)));
    endtask

    task automatic test_reset_state();
        send_item(lfcr_pkg::ACT_READ, 8'h00, 8'hFF);
    endtask

    task automatic test_basic_frame();
        send_byte(8'd5);
        send_ticks(1);
        send_byte(8'hA5);
        send_byte(8'h81);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_item(lfcr_pkg::ACT_READ, 8'hFF, 8'd2);
        send_item(lfcr_pkg::ACT_READ, 8'h00, 8'd4);
    endtask

    task automatic test_release();
        send_byte(8'd7);
        send_byte(8'h3C);
        send_item(lfcr_pkg::ACT_RELEASE, 8'h00, 8'h00);
    endtask

    // A late command that is also bad must report the bad command.
    task automatic test_header_drops();
        wait_drained();
        write_reg(lfcr_pkg::CFG_TIMEOUT, 16'd0);
        send_byte(8'd6);
        send_byte(8'h10);
        send_ticks(1);
        send_byte(8'h00);
        send_byte(8'd6);
        send_ticks(1);
        send_byte(8'h20);
        send_byte(8'd6);
        send_byte(8'h30);
        send_ticks(1);
        send_byte(8'h82);
    endtask

    task automatic test_master_mode();
        wait_drained();
        write_reg(lfcr_pkg::CFG_MASTER_MODE, 16'd1);
        send_byte(8'd4);
        send_byte(8'h55);
        send_byte(8'h03);
        send_byte(8'hC3);
        send_item(lfcr_pkg::ACT_READ, 8'h00, 8'd3);
    endtask

    // Lengths below four only end when the byte count wraps round.
    task automatic test_count_wrap();
        send_frame(8'd0, 1'b0);
        send_frame(8'd3, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        int unsigned pick;
        logic [15:0] tmo;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int k = 0; k < 4; k++)
            begin
                wait_drained();
                case ($urandom_range(4))
                    0:       tmo = 16'd0;
                    1:       tmo = 16'($urandom_range(1, 6));
                    2:       tmo = lfcr_pkg::GAP_MAX;
                    3:       tmo = lfcr_pkg::TIMEOUT_RESET;
                    default: tmo = 16'($urandom);
                endcase
                write_reg(lfcr_pkg::CFG_MASTER_MODE, {15'($urandom), 1'($urandom)});
                write_reg(lfcr_pkg::CFG_TIMEOUT, tmo);
                write_reg(lfcr_pkg::CFG_WRITE_CODE, {9'($urandom), pick_code()});
                write_reg(lfcr_pkg::CFG_READ_CODE, {9'($urandom), pick_code()});
                write_reg(lfcr_pkg::CFG_SETUP_CODE, {9'($urandom), pick_code()});
                target = items_sent + 55;
                while (items_sent < target)
                begin
                    pick = $urandom_range(199);
                    if (pick < 20)
                        send_item(2'($urandom), 8'($urandom), 8'($urandom));
                    else if (pick < 28)
                        send_item(lfcr_pkg::ACT_READ, 8'($urandom), 8'($urandom));
                    else if (pick < 29)
                        send_frame(8'($urandom_range(0, 3)), 1'b1);
                    else if (pick < 50)
                        send_frame(8'($urandom_range(17, 60)), 1'b1);
                    else
                        send_frame(8'($urandom_range(4, 16)), 1'b1);
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = lfcr_pkg::ACT_BYTE;
        rx_byte        = '0;
        read_index     = '0;
        out_ready      = 1'b1;
        cfg_valid      = 1'b0;
        cfg_index      = lfcr_pkg::CFG_MASTER_MODE;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        items_sent     = 0;
        quiet_cycles   = 0;
        hdr_phase      = HDR_LENGTH;
        rx_count       = '0;
        frame_len      = '0;
        tick_gap       = '0;
        fill_bank      = 1'b0;
        ready_bank     = 1'b0;
        req_flag       = 1'b0;
        rep_flag       = 1'b0;
        cfg_master     = 1'b0;
        cfg_timeout    = lfcr_pkg::TIMEOUT_RESET;
        cfg_write_code = lfcr_pkg::WRITE_RESET;
        cfg_read_code  = lfcr_pkg::READ_RESET;
        cfg_setup_code = lfcr_pkg::SETUP_RESET;
        for (int i = 0; i < BANK_BYTES; i++)
        begin
            bank_mem[0][i] = '0;
            bank_mem[1][i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_basic_frame();
        test_release();
        test_header_drops();
        test_master_mode();
        test_count_wrap();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
